/* hdl/framed_packet_receiver_defines.svh */
// ----------------------------------------------------------------------------
// framed_packet_receiver_defines
// assertion macros for the framed packet receiver
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_RECEIVER_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
`define FRX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FRX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FRX_ASSERT(lbl, prop, msg)
`define FRX_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/frx_pkg.sv */
// ----------------------------------------------------------------------------
// frx_pkg
// shared types and constants of the framed packet receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frx_pkg;

  localparam int unsigned MaxPayloadDefault = 32;

  localparam logic [7:0] ChrU     = 8'h55;
  localparam logic [7:0] ChrN     = 8'h4E;
  localparam logic [7:0] ChrE     = 8'h45;
  localparam logic [7:0] ChrR     = 8'h52;
  localparam logic [7:0] ChrColon = 8'h3A;
  localparam logic [7:0] HdrXor   = ChrU ^ ChrN ^ ChrE ^ ChrR ^ ChrColon;

  typedef enum logic [1:0] {
    STATUS_DATA     = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_CKS_ERR  = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } frame_status_e;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_GOT_U,
    ST_GOT_N,
    ST_GOT_E,
    ST_LEN,
    ST_COLON,
    ST_BODY,
    ST_DRAIN
  } frx_state_e;

  typedef struct packed {
    logic load_len;
    logic start_body;
    logic body_beat;
    logic finish;
    logic drain_step;
  } dp_cmd_t;

  typedef struct packed {
    logic is_u;
    logic is_n;
    logic is_e;
    logic is_r;
    logic is_colon;
    logic rem_gt1;
    logic has_payload;
    logic drain_last;
    logic out_ready;
  } dp_status_t;

endpackage

/* hdl/framed_packet_receiver.sv */
// ----------------------------------------------------------------------------
// framed_packet_receiver
// serial frame deframer with xor checksum check
// ----------------------------------------------------------------------------
// input channel: one received byte per beat on rx_byte_i, in_valid_i/in_stall_o.
// output channel: one result per beat, out_valid_o/out_stall_i, carrying
//   payload_byte_o, frame_status_o and last_of_frame_o.
// a byte is taken every cycle while hunting, in the header and in the body,
//   unless the output register holds a stalled beat. on the checksum byte
//   a status result (error, overflow, empty frame) shows in the next cycle;
//   a good frame is then drained from the payload store, one beat per cycle
//   unless the output stalls, from the drain state on, with input stalled.
// the drain rate is set by the single read port of the payload store.
// when the receiver stalls, the output register holds its beat and input
//   is stalled until that beat is taken.
// reset clears the hunt state, counters and the output valid; the payload
//   store needs no clearing since only entries of the current frame are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "framed_packet_receiver_defines.svh"

module framed_packet_receiver #(
  parameter int unsigned MAX_PAYLOAD = frx_pkg::MaxPayloadDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic [1:0] frame_status_o,
  output logic       last_of_frame_o
);

  frx_pkg::dp_cmd_t    cmd;
  frx_pkg::dp_status_t dp_status;

  frx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  frx_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_byte_i       (rx_byte_i),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .payload_byte_o  (payload_byte_o),
    .frame_status_o  (frame_status_o),
    .last_of_frame_o (last_of_frame_o)
  );

  `FRX_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
  `FRX_ASSERT(a_no_input_in_drain, !(cmd.drain_step && in_valid_i && !in_stall_o), "drain took a byte")
  `FRX_ASSERT(a_finish_has_room, !cmd.finish || dp_status.out_ready, "beat overwritten")
  `FRX_ASSERT_NEXT(a_drain_shows, cmd.drain_step, out_valid_o, "drained beat not presented")

endmodule

/* hdl/frx_datapath.sv */
// ----------------------------------------------------------------------------
// frx_datapath
// length, checksum and index registers, payload store and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frx_datapath #(
  parameter int unsigned MAX_PAYLOAD = frx_pkg::MaxPayloadDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           rx_byte_i,
  input  frx_pkg::dp_cmd_t     cmd_i,
  output frx_pkg::dp_status_t  status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           payload_byte_o,
  output logic [1:0]           frame_status_o,
  output logic                 last_of_frame_o
);

  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]    mem [MAX_PAYLOAD];
  logic [7:0]    rem_q, rem_d;
  logic [7:0]    xor_q, xor_d;
  logic [CW-1:0] wr_idx_q, wr_idx_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic          ovf_q, ovf_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_data_q;
  frx_pkg::frame_status_e out_status_q;
  logic          out_last_q;
  logic          room;
  logic          cks_ok;
  logic          store_we;
  logic          drain_last;

  assign room       = wr_idx_q < CW'(MAX_PAYLOAD);
  assign cks_ok     = xor_q == rx_byte_i;
  assign store_we   = cmd_i.body_beat && room;
  assign drain_last = (rd_idx_q + CW'(1)) == wr_idx_q;

  always_comb begin
    status_o.is_u        = rx_byte_i == frx_pkg::ChrU;
    status_o.is_n        = rx_byte_i == frx_pkg::ChrN;
    status_o.is_e        = rx_byte_i == frx_pkg::ChrE;
    status_o.is_r        = rx_byte_i == frx_pkg::ChrR;
    status_o.is_colon    = rx_byte_i == frx_pkg::ChrColon;
    status_o.rem_gt1     = rem_q > 8'd1;
    status_o.has_payload = cks_ok && !ovf_q && (wr_idx_q != '0);
    status_o.drain_last  = drain_last;
    status_o.out_ready   = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    rem_d       = rem_q;
    xor_d       = xor_q;
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load_len) begin
      rem_d = rx_byte_i;
    end
    if (cmd_i.start_body) begin
      wr_idx_d = '0;
      ovf_d    = 1'b0;
      xor_d    = frx_pkg::HdrXor ^ rem_q;
    end
    if (cmd_i.body_beat) begin
      rem_d = rem_q - 8'd1;
      xor_d = xor_q ^ rx_byte_i;
      if (room) begin
        wr_idx_d = wr_idx_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.finish) begin
      rem_d    = '0;
      rd_idx_d = '0;
      if (!status_o.has_payload) begin
        out_valid_d = 1'b1;
      end
    end
    if (cmd_i.drain_step) begin
      rd_idx_d    = rd_idx_q + CW'(1);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      xor_q       <= '0;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      xor_q       <= xor_d;
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      mem[wr_idx_q[AW-1:0]] <= rx_byte_i;
    end
  end

  // status beats and payload beats share the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.drain_step) begin
      out_data_q   <= mem[rd_idx_q[AW-1:0]];
      out_status_q <= frx_pkg::STATUS_DATA;
      out_last_q   <= drain_last;
    end else if (cmd_i.finish && !status_o.has_payload) begin
      out_data_q <= '0;
      out_last_q <= 1'b1;
      if (!cks_ok) begin
        out_status_q <= frx_pkg::STATUS_CKS_ERR;
      end else if (ovf_q) begin
        out_status_q <= frx_pkg::STATUS_OVERFLOW;
      end else begin
        out_status_q <= frx_pkg::STATUS_EMPTY;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = out_data_q;
  assign frame_status_o  = out_status_q;
  assign last_of_frame_o = out_last_q;

endmodule

/* hdl/frx_ctrl.sv */
// ----------------------------------------------------------------------------
// frx_ctrl
// frame hunting and payload drain sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frx_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  frx_pkg::dp_status_t status_i,
  output frx_pkg::dp_cmd_t    cmd_o
);

  frx_pkg::frx_state_e state_q, state_d;
  logic                accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frx_pkg::ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q == frx_pkg::ST_DRAIN) || !status_i.out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      frx_pkg::ST_HUNT: begin
        if (accept && status_i.is_u) begin
          state_d = frx_pkg::ST_GOT_U;
        end
      end
      frx_pkg::ST_GOT_U: begin
        if (accept) begin
          state_d = status_i.is_n ? frx_pkg::ST_GOT_N
                  : (status_i.is_u ? frx_pkg::ST_GOT_U : frx_pkg::ST_HUNT);
        end
      end
      frx_pkg::ST_GOT_N: begin
        if (accept) begin
          state_d = status_i.is_e ? frx_pkg::ST_GOT_E
                  : (status_i.is_u ? frx_pkg::ST_GOT_U : frx_pkg::ST_HUNT);
        end
      end
      frx_pkg::ST_GOT_E: begin
        if (accept) begin
          state_d = status_i.is_r ? frx_pkg::ST_LEN
                  : (status_i.is_u ? frx_pkg::ST_GOT_U : frx_pkg::ST_HUNT);
        end
      end
      frx_pkg::ST_LEN: begin
        if (accept) begin
          cmd_o.load_len = 1'b1;
          state_d        = frx_pkg::ST_COLON;
        end
      end
      frx_pkg::ST_COLON: begin
        if (accept) begin
          if (status_i.is_colon) begin
            cmd_o.start_body = 1'b1;
            state_d          = frx_pkg::ST_BODY;
          end else begin
            state_d = status_i.is_u ? frx_pkg::ST_GOT_U : frx_pkg::ST_HUNT;
          end
        end
      end
      frx_pkg::ST_BODY: begin
        if (accept) begin
          if (status_i.rem_gt1) begin
            cmd_o.body_beat = 1'b1;
          end else begin
            cmd_o.finish = 1'b1;
            state_d = status_i.has_payload ? frx_pkg::ST_DRAIN : frx_pkg::ST_HUNT;
          end
        end
      end
      frx_pkg::ST_DRAIN: begin
        if (status_i.out_ready) begin
          cmd_o.drain_step = 1'b1;
          if (status_i.drain_last) begin
            state_d = frx_pkg::ST_HUNT;
          end
        end
      end
      default: begin
        state_d = frx_pkg::ST_HUNT;
      end
    endcase
  end

endmodule

/* bench/framed_packet_receiver_tb.sv */
// ----------------------------------------------------------------------------
// framed_packet_receiver_tb
// self-checking bench for the framed packet receiver
// ----------------------------------------------------------------------------
// feeds received bytes through the input channel: a short directed part, then
// mostly well-formed frames with random payload, mixed with broken headers,
// bad checksums and noise, over three idle/stall mixes. a scoreboard tracks
// the deframer state per accepted byte and checks every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module framed_packet_receiver_tb;

  localparam int unsigned PayloadMax    = frx_pkg::MaxPayloadDefault;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned TailCycles    = 20;
  localparam int unsigned PhaseBytes    = 24;
  localparam logic [31:0] HeaderWord    = {frx_pkg::ChrU, frx_pkg::ChrN,
                                           frx_pkg::ChrE, frx_pkg::ChrR};

  typedef struct {
    logic [7:0]             data;
    frx_pkg::frame_status_e status;
    logic                   last;
  } frame_result_t;

  class frame_checker;
    frx_pkg::frx_state_e state;
    logic [7:0]          remaining;
    logic [7:0]          cks;
    int unsigned         fill;
    bit                  over;
    logic [7:0]          store [PayloadMax];
    frame_result_t       due_results [$];
    int unsigned         errors;

    function new();
      state     = frx_pkg::ST_HUNT;
      remaining = '0;
      cks       = '0;
      fill      = 0;
      over      = 1'b0;
      errors    = 0;
    endfunction

    function frx_pkg::frx_state_e restart(logic [7:0] b);
      return (b == frx_pkg::ChrU) ? frx_pkg::ST_GOT_U : frx_pkg::ST_HUNT;
    endfunction

    function void push(logic [7:0] data, frx_pkg::frame_status_e status, logic last);
      due_results.push_back('{data: data, status: status, last: last});
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void take_rx_byte(logic [7:0] b);
      case (state)
        frx_pkg::ST_HUNT:  state = restart(b);
        frx_pkg::ST_GOT_U: state = (b == frx_pkg::ChrN) ? frx_pkg::ST_GOT_N : restart(b);
        frx_pkg::ST_GOT_N: state = (b == frx_pkg::ChrE) ? frx_pkg::ST_GOT_E : restart(b);
        frx_pkg::ST_GOT_E: state = (b == frx_pkg::ChrR) ? frx_pkg::ST_LEN : restart(b);
        frx_pkg::ST_LEN: begin
          remaining = b;
          state     = frx_pkg::ST_COLON;
        end
        frx_pkg::ST_COLON: begin
          if (b == frx_pkg::ChrColon) begin
            state = frx_pkg::ST_BODY;
            fill  = 0;
            over  = 1'b0;
            cks   = frx_pkg::HdrXor ^ remaining;
          end else begin
            state = restart(b);
          end
        end
        frx_pkg::ST_BODY: begin
          if (remaining > 8'd1) begin
            remaining = remaining - 8'd1;
            if (fill < PayloadMax) begin
              store[fill] = b;
              fill++;
            end else begin
              over = 1'b1;
            end
            cks = cks ^ b;
          end else begin
            remaining = '0;
            state     = frx_pkg::ST_HUNT;
            if (cks != b) begin
              push(8'h00, frx_pkg::STATUS_CKS_ERR, 1'b1);
            end else if (over) begin
              push(8'h00, frx_pkg::STATUS_OVERFLOW, 1'b1);
            end else if (fill == 0) begin
              push(8'h00, frx_pkg::STATUS_EMPTY, 1'b1);
            end else begin
              for (int i = 0; i < fill; i++) begin
                push(store[i], frx_pkg::STATUS_DATA, (i + 1 == fill));
              end
            end
          end
        end
        default:  state = restart(b);
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task match_result(logic [7:0] data, logic [1:0] status, logic last);
      frame_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected beat data %02h status %0d last %0b", data, status, last));
        return;
      end
      want = due_results.pop_front();
      if (data !== want.data) begin
        report($sformatf("payload_byte %02h, want %02h", data, want.data));
      end
      if (status !== want.status) begin
        report($sformatf("frame_status %0d, want %s", status, want.status.name()));
      end
      if (last !== want.last) begin
        report($sformatf("last_of_frame %0b, want %0b", last, want.last));
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] payload_byte_o;
  logic [1:0] frame_status_o;
  logic       last_of_frame_o;

  frame_checker chk;
  int unsigned  src_idle_pct;
  int unsigned  sink_idle_pct;
  int unsigned  bytes_sent;
  int unsigned  idle_cycles;

  framed_packet_receiver #(
    .MAX_PAYLOAD(PayloadMax)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .payload_byte_o (payload_byte_o),
    .frame_status_o (frame_status_o),
    .last_of_frame_o(last_of_frame_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        chk.match_result(payload_byte_o, frame_status_o, last_of_frame_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("framed_packet_receiver_tb: done, errors");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chk.take_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] len_byte, input bit bad_cks);
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned n_pay;
    n_pay = (len_byte == 8'd0) ? 0 : len_byte - 1;
    sum   = frx_pkg::HdrXor ^ len_byte;
    send_byte(frx_pkg::ChrU);
    send_byte(frx_pkg::ChrN);
    send_byte(frx_pkg::ChrE);
    send_byte(frx_pkg::ChrR);
    send_byte(len_byte);
    send_byte(frx_pkg::ChrColon);
    repeat (n_pay) begin
      b   = 8'($urandom_range(255));
      sum = sum ^ b;
      send_byte(b);
    end
    if (bad_cks) begin
      sum = sum ^ 8'($urandom_range(1, 255));
    end
    send_byte(sum);
  endtask

  // header cut short by a wrong byte, or a full header with a bad colon
  task automatic send_broken_header();
    int unsigned k;
    logic [7:0]  b;
    logic [7:0]  want;
    k = $urandom_range(1, 4);
    for (int i = 0; i < k; i++) begin
      send_byte(HeaderWord[31 - 8 * i -: 8]);
    end
    if (k == 4) begin
      send_byte(8'($urandom_range(255)));
      want = frx_pkg::ChrColon;
    end else begin
      want = HeaderWord[31 - 8 * k -: 8];
    end
    b = 8'($urandom_range(255));
    if (b == want) begin
      b = ~b;
    end
    send_byte(b);
  endtask

  task automatic random_traffic(input logic [7:0] forced_len, input bit forced_bad);
    int unsigned start;
    int unsigned pick;
    start = bytes_sent;
    send_frame(forced_len, forced_bad);
    while (bytes_sent - start < PhaseBytes) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_frame(8'($urandom_range(0, 7)), 1'b0);
      end else if (pick < 78) begin
        send_frame(8'($urandom_range(0, 7)), 1'b1);
      end else if (pick < 90) begin
        send_broken_header();
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    chk           = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    rx_byte_i     = 8'h00;
    src_idle_pct  = 16;
    sink_idle_pct = 57;
    bytes_sent    = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wrong third header byte retried as a start, then a zero-length frame
    send_byte(frx_pkg::ChrU);
    send_byte(frx_pkg::ChrN);
    send_frame(8'h00, 1'b0);
    // start char in the colon slot, then a bad checksum over an all-ones beat
    send_byte(frx_pkg::ChrU);
    send_byte(frx_pkg::ChrN);
    send_byte(frx_pkg::ChrE);
    send_byte(frx_pkg::ChrR);
    send_byte(8'h02);
    send_byte(frx_pkg::ChrU);
    send_byte(frx_pkg::ChrN);
    send_byte(frx_pkg::ChrE);
    send_byte(frx_pkg::ChrR);
    send_byte(8'h02);
    send_byte(frx_pkg::ChrColon);
    send_byte(8'hFF);
    send_byte(frx_pkg::HdrXor ^ 8'h02 ^ 8'hFF ^ 8'h01);
    wait_for_results();

    // full store, then one past it, then a short frame with a bad checksum
    random_traffic(8'(PayloadMax + 1), 1'b0);
    wait_for_results();
    src_idle_pct  = 57;
    sink_idle_pct = 16;
    random_traffic(8'(PayloadMax + 2), 1'b0);
    wait_for_results();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    random_traffic(8'd5, 1'b1);
    wait_for_results();

    repeat (TailCycles) @(posedge clk_i);
    if (chk.errors == 0) begin
      $display("framed_packet_receiver_tb: done, clean");
    end else begin
      $display("framed_packet_receiver_tb: done, errors");
    end
    $finish;
  end

endmodule
